FILE: hw/rtl/counter_priority_task_scheduler_unit_macros.svh
// Assertion macros shared by the scheduler checker.
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_UNIT_MACROS_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_UNIT_MACROS_SVH

// Check cons in the same cycle as ante.
`define CPTS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define CPTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/cpts_pkg.sv
// Types and constants of the counter/priority task scheduler.
package cpts_pkg;

   localparam int NUM_TASKS_DEF = 8;
   localparam int SLOT_W        = 3;
   localparam int PRIO_W        = 7;
   localparam int CNT_W         = 8;

   // request codes
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // per-slot attributes, stored beside the counter memory
   typedef struct packed {
      logic              present;
      logic              runnable;
      logic [PRIO_W-1:0] prio;
   } attr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REFILL,
      ST_DONE
   } state_type;

endpackage

FILE: hw/rtl/cpts_if.sv
// Request and response channel interfaces of the scheduler.
interface cpts_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [cpts_pkg::SLOT_W-1:0] slot;
   logic [cpts_pkg::PRIO_W-1:0] prio;
   logic                        present;
   logic                        runnable;

   modport source (output valid, req_type, slot, prio, present, runnable, input ready);
   modport sink   (input valid, req_type, slot, prio, present, runnable, output ready);
endinterface

interface cpts_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [cpts_pkg::SLOT_W-1:0] current_slot;
   logic [cpts_pkg::CNT_W-1:0]  current_count;
   logic                        switched;
   logic                        refilled;
   logic                        none_ready;

   modport source (output valid, current_slot, current_count, switched, refilled, none_ready,
                   input ready);
   modport sink   (input valid, current_slot, current_count, switched, refilled, none_ready,
                   output ready);
endinterface

FILE: hw/rtl/cpts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cpts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/counter_priority_task_scheduler_unit.sv
// Counter/priority task scheduler: slot table in two RAMs, scan/refill sequencer.
// A write word, or a tick that leaves the slice nonzero, answers in the cycle after accept.
// A tick that picks a task answers after the scan pass, or after scan, refill and rescan passes;
// each pass reads one counter RAM entry per cycle. One word is in work at a time; the next is
// taken once the scheduler is idle and the response register is free or being drained.
// Reset (synchronous) clears the valid bits and makes idle current; RAMs are not swept.
module counter_priority_task_scheduler_unit #(
   parameter int NUM_TASKS = cpts_pkg::NUM_TASKS_DEF
) (
   input logic            clock,
   input logic            reset,
   cpts_req_if.sink       req_ch,
   cpts_rsp_if.source     rsp_ch
);

   localparam int IW = $clog2(NUM_TASKS);
   localparam int SW = cpts_pkg::SLOT_W;
   localparam int CW = cpts_pkg::CNT_W;
   localparam int AW = $bits(cpts_pkg::attr_type);
   localparam logic [IW-1:0] FIRST_IDX = IW'(1);
   localparam logic [IW-1:0] LAST_IDX  = IW'(NUM_TASKS - 1);

   // sequencer state
   cpts_pkg::state_type state_ff, state_in;
   logic [IW-1:0]        idx_ff;          // next entry to read
   logic                 issue_done_ff;   // all reads of this pass issued
   logic                 eval_vld_ff;     // RAM data of eval_idx_ff is on the read port
   logic [IW-1:0]        eval_idx_ff;
   logic                 ent_valid_ff;    // entry was written since reset
   logic                 pass2_ff;        // second scan, after the refill
   logic [IW-1:0]        best_idx_ff;
   logic [CW-1:0]        best_cnt_ff;

   // architectural state outside the RAMs
   logic [NUM_TASKS-1:0] valid_ff;
   logic [IW-1:0]        cur_ff;
   logic [CW-1:0]        cur_count_ff;
   logic                 sw_ff, rf_ff, nr_ff;

   // response register
   logic                 rsp_valid_ff;
   logic [SW-1:0]        rsp_slot_ff, rsp_slot_in;
   logic [CW-1:0]        rsp_count_ff, rsp_count_in;
   logic                 rsp_sw_ff, rsp_sw_in;
   logic                 rsp_rf_ff, rsp_rf_in;
   logic                 rsp_nr_ff, rsp_nr_in;
   logic                 rsp_load;

   // RAM ports
   logic                 cnt_we;
   logic [IW-1:0]        cnt_waddr;
   logic [CW-1:0]        cnt_wdata;
   logic [CW-1:0]        cnt_rdata;
   logic                 attr_we;
   cpts_pkg::attr_type   attr_wdata;
   cpts_pkg::attr_type   attr_rdata;
   logic                 rd_en;

   // decode
   logic                 out_free;
   logic                 req_fire;
   logic                 is_write;
   logic                 wr_ok;
   logic [IW-1:0]        wr_idx;
   logic                 wr_hits_cur;
   logic [CW-1:0]        cnt_dec;
   logic                 tick_live;
   logic                 tick_keep;

   // scan datapath
   logic                 eff_present;
   logic                 eff_runnable;
   logic [CW-1:0]        eff_cnt;
   logic [cpts_pkg::PRIO_W-1:0] eff_prio;
   logic                 cand_better;
   logic [IW-1:0]        best_idx_nx;
   logic [CW-1:0]        best_cnt_nx;
   logic                 eval_last_scan;
   logic                 eval_last_refill;
   logic                 scan_finish;
   logic                 scan_start;
   logic                 refill_start;
   logic [CW-1:0]        refill_val;

   cpts_ram #(.WIDTH(CW), .DEPTH(NUM_TASKS)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (cnt_rdata)
   );

   cpts_ram #(.WIDTH(AW), .DEPTH(NUM_TASKS)) u_attr_ram (
      .clock   (clock),
      .wr_en   (attr_we),
      .wr_addr (wr_idx),
      .wr_data (attr_wdata),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (attr_rdata)
   );

   // Accept only when idle and the response register can take the answer.
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == cpts_pkg::ST_IDLE) && out_free;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign is_write     = (req_ch.req_type == cpts_pkg::REQ_WRITE);

   // Slot zero is the idle task and slots past the table do not exist: drop such writes.
   assign wr_ok        = (req_ch.slot != '0) && (32'(req_ch.slot) < 32'(NUM_TASKS));
   assign wr_idx       = IW'(req_ch.slot);
   assign wr_hits_cur  = wr_ok && (wr_idx == cur_ff);

   // Charge one unit to a running task; keep it if slice remains.
   assign cnt_dec      = cur_count_ff - CW'(1);
   assign tick_live    = (cur_ff != '0) && (cur_count_ff != '0);
   assign tick_keep    = tick_live && (cnt_dec != '0);

   // Entries never written read as all zero.
   assign eff_present  = ent_valid_ff && attr_rdata.present;
   assign eff_runnable = ent_valid_ff && attr_rdata.runnable;
   assign eff_cnt      = ent_valid_ff ? cnt_rdata : '0;
   assign eff_prio     = ent_valid_ff ? attr_rdata.prio : '0;

   // Scan runs from the top slot down; strict compare keeps the higher slot on a tie.
   assign cand_better  = eval_vld_ff && eff_present && eff_runnable && (eff_cnt > best_cnt_ff);
   assign best_idx_nx  = cand_better ? eval_idx_ff : best_idx_ff;
   assign best_cnt_nx  = cand_better ? eff_cnt : best_cnt_ff;

   assign eval_last_scan   = eval_vld_ff && (eval_idx_ff == FIRST_IDX);
   assign eval_last_refill = eval_vld_ff && (eval_idx_ff == LAST_IDX);
   assign scan_finish      = (state_ff == cpts_pkg::ST_SCAN) && eval_last_scan &&
                             ((best_idx_nx != '0) || pass2_ff);

   // counter/2 + priority stays below 255, no saturation needed
   assign refill_val   = (eff_cnt >> 1) + CW'(eff_prio);

   assign scan_start   = (state_in == cpts_pkg::ST_SCAN)   && (state_ff != cpts_pkg::ST_SCAN);
   assign refill_start = (state_in == cpts_pkg::ST_REFILL) && (state_ff != cpts_pkg::ST_REFILL);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cpts_pkg::ST_IDLE: begin
            if (req_fire && !is_write && !tick_keep) begin
               state_in = cpts_pkg::ST_SCAN;
            end
         end
         cpts_pkg::ST_SCAN: begin
            if (eval_last_scan) begin
               if ((best_idx_nx == '0) && !pass2_ff) begin
                  state_in = cpts_pkg::ST_REFILL;
               end else begin
                  state_in = cpts_pkg::ST_DONE;
               end
            end
         end
         cpts_pkg::ST_REFILL: begin
            if (eval_last_refill) begin
               state_in = cpts_pkg::ST_SCAN;
            end
         end
         cpts_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = cpts_pkg::ST_IDLE;
            end
         end
         default: state_in = cpts_pkg::ST_IDLE;
      endcase
   end

   // RAM control and response selection
   always_comb begin
      rd_en        = 1'b0;
      cnt_we       = 1'b0;
      cnt_waddr    = cur_ff;
      cnt_wdata    = cnt_dec;
      attr_we      = 1'b0;
      attr_wdata   = '{present: req_ch.present, runnable: req_ch.runnable, prio: req_ch.prio};
      rsp_load     = 1'b0;
      rsp_slot_in  = SW'(cur_ff);
      rsp_count_in = cur_count_ff;
      rsp_sw_in    = 1'b0;
      rsp_rf_in    = 1'b0;
      rsp_nr_in    = 1'b0;
      case (state_ff)
         cpts_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (is_write) begin
                  // load the slot, slice starts empty
                  cnt_we       = wr_ok;
                  cnt_waddr    = wr_idx;
                  cnt_wdata    = '0;
                  attr_we      = wr_ok;
                  rsp_load     = 1'b1;
                  rsp_count_in = wr_hits_cur ? '0 : cur_count_ff;
               end else begin
                  cnt_we       = tick_live;
                  rsp_load     = tick_keep;
                  rsp_count_in = cnt_dec;
               end
            end
         end
         cpts_pkg::ST_SCAN: begin
            rd_en = !issue_done_ff;
         end
         cpts_pkg::ST_REFILL: begin
            rd_en     = !issue_done_ff;
            cnt_we    = eval_vld_ff && eff_present;
            cnt_waddr = eval_idx_ff;
            cnt_wdata = refill_val;
         end
         cpts_pkg::ST_DONE: begin
            rsp_load  = out_free;
            rsp_sw_in = sw_ff;
            rsp_rf_in = rf_ff;
            rsp_nr_in = nr_ff;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cpts_pkg::ST_IDLE;
         issue_done_ff <= 1'b1;
         eval_vld_ff   <= 1'b0;
         pass2_ff      <= 1'b0;
         valid_ff      <= '0;
         cur_ff        <= '0;
         cur_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         eval_vld_ff <= rd_en;

         if (scan_start || refill_start) begin
            issue_done_ff <= 1'b0;
         end else if (rd_en) begin
            if (state_ff == cpts_pkg::ST_SCAN) begin
               issue_done_ff <= (idx_ff == FIRST_IDX);
            end else begin
               issue_done_ff <= (idx_ff == LAST_IDX);
            end
         end

         // the second scan follows the refill pass
         if (refill_start) begin
            pass2_ff <= 1'b1;
         end else if (req_fire) begin
            pass2_ff <= 1'b0;
         end

         if (req_fire && is_write && wr_ok) begin
            valid_ff[wr_idx] <= 1'b1;
         end

         // mirror the current task's counter to answer without a RAM read
         if (req_fire) begin
            if (is_write) begin
               if (wr_hits_cur) begin
                  cur_count_ff <= '0;
               end
            end else if (tick_live) begin
               cur_count_ff <= cnt_dec;
            end
         end else if (scan_finish) begin
            cur_ff       <= best_idx_nx;
            cur_count_ff <= best_cnt_nx;
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      eval_idx_ff  <= idx_ff;
      ent_valid_ff <= valid_ff[idx_ff];

      if (scan_start) begin
         idx_ff      <= LAST_IDX;
         best_idx_ff <= '0;
         best_cnt_ff <= '0;
      end else if (refill_start) begin
         idx_ff <= FIRST_IDX;
      end else begin
         if (rd_en) begin
            if (state_ff == cpts_pkg::ST_SCAN) begin
               idx_ff <= idx_ff - IW'(1);
            end else begin
               idx_ff <= idx_ff + IW'(1);
            end
         end
         if (state_ff == cpts_pkg::ST_SCAN) begin
            best_idx_ff <= best_idx_nx;
            best_cnt_ff <= best_cnt_nx;
         end
      end

      if (scan_finish) begin
         sw_ff <= (best_idx_nx != cur_ff);
         rf_ff <= pass2_ff;
         nr_ff <= pass2_ff && (best_idx_nx == '0);
      end

      if (rsp_load) begin
         rsp_slot_ff  <= rsp_slot_in;
         rsp_count_ff <= rsp_count_in;
         rsp_sw_ff    <= rsp_sw_in;
         rsp_rf_ff    <= rsp_rf_in;
         rsp_nr_ff    <= rsp_nr_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.current_slot  = rsp_slot_ff;
   assign rsp_ch.current_count = rsp_count_ff;
   assign rsp_ch.switched      = rsp_sw_ff;
   assign rsp_ch.refilled      = rsp_rf_ff;
   assign rsp_ch.none_ready    = rsp_nr_ff;

endmodule

FILE: hw/rtl/cpts_checker.sv
// Port-level assertions for the scheduler, bound to the top level.
`include "counter_priority_task_scheduler_unit_macros.svh"

module cpts_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_type,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [cpts_pkg::SLOT_W-1:0] current_slot,
   input logic [cpts_pkg::CNT_W-1:0]  current_count,
   input logic                        switched,
   input logic                        refilled,
   input logic                        none_ready
);

   `CPTS_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid, "response valid after reset")

   `CPTS_ASSERT_NEXT(a_write_answer, clock, reset, req_valid && req_ready && (req_type == cpts_pkg::REQ_WRITE), rsp_valid && !switched && !refilled && !none_ready, "write word not answered plainly next cycle")

   `CPTS_ASSERT_SAME(a_none_idle, clock, reset, rsp_valid && none_ready, refilled && (current_slot == '0) && (current_count == '0), "none_ready without refill or idle")

   `CPTS_ASSERT_SAME(a_switch_slice, clock, reset, rsp_valid && switched && (current_slot != '0), current_count != '0, "switched to a task with an empty slice")

   `CPTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(current_slot) && $stable(current_count) && $stable(switched), "stalled response word changed")

endmodule

bind counter_priority_task_scheduler_unit cpts_checker u_cpts_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_type      (req_ch.req_type),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .current_slot  (rsp_ch.current_slot),
   .current_count (rsp_ch.current_count),
   .switched      (rsp_ch.switched),
   .refilled      (rsp_ch.refilled),
   .none_ready    (rsp_ch.none_ready)
);
